### rtl/core/fba_pkg.sv
// Shared types, widths and codes for the fit block allocator.
`timescale 1ns / 1ps

package fba_pkg;

  // Default geometry of the block table
  localparam int BLOCK_COUNT_DEF = 16;
  localparam int SIZE_BITS_DEF   = 16;

  // Fixed field widths of the stream and configuration ports
  localparam int ACT_W      = 2;
  localparam int IDX_FLD_W  = 4;
  localparam int SIZE_FLD_W = 16;
  localparam int SUM_W      = 20;
  localparam int MODE_W     = 2;
  localparam int NUMB_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 2'd1;

  // Request kinds
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  // Search policies
  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic clr_all;
    logic scan_clr;
    logic scan_issue;
    logic finish;
  } fba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_end;
  } fba_sts_t;

endpackage

### rtl/core/fba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fba_ctrl.sv
// Sequencing state machine of the fit block allocator.
`timescale 1ns / 1ps

module fba_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fba_pkg::ACT_W-1:0]      in_action_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output fba_pkg::fba_cmd_t              cmd_o,
  input  fba_pkg::fba_sts_t              sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and commands for the datapath.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_FINISH;
          case (in_action_i)
            fba_pkg::ACT_LOAD:    cmd_o.load_wr = 1'b1;
            fba_pkg::ACT_RELEASE: cmd_o.clr_all = 1'b1;
            fba_pkg::ACT_ALLOC: begin
              cmd_o.scan_clr = 1'b1;
              state_d        = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // The compare of the last read entry lands in the cycle that sees the end.
        if (sts_i.scan_end) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.scan_issue = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_alloc_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_action_i == fba_pkg::ACT_ALLOC) |=> (state_q == ST_SCAN))
    else $error("allocate request did not start a scan");
  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finished request left no result");
  a_scan_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && sts_i.scan_end) |=> (state_q == ST_FINISH))
    else $error("scan end did not lead to finish");
`endif

endmodule

### rtl/core/fba_datapath.sv
// Block table, busy marks, search compare and result registers.
`timescale 1ns / 1ps

module fba_datapath #(
  parameter int BLOCK_COUNT = fba_pkg::BLOCK_COUNT_DEF,
  parameter int SIZE_BITS   = fba_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fba_pkg::fba_cmd_t                cmd_i,
  output fba_pkg::fba_sts_t                sts_o,
  input  logic                             cfg_valid_i,
  input  logic [fba_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fba_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [fba_pkg::ACT_W-1:0]        action_i,
  input  logic [fba_pkg::IDX_FLD_W-1:0]    block_index_i,
  input  logic [fba_pkg::SIZE_FLD_W-1:0]   block_size_i,
  input  logic [fba_pkg::SIZE_FLD_W-1:0]   request_size_i,
  output logic                             granted_o,
  output logic [fba_pkg::IDX_FLD_W-1:0]    granted_block_o,
  output logic [fba_pkg::SIZE_FLD_W-1:0]   fragment_o,
  output logic [fba_pkg::SUM_W-1:0]        total_fragment_o
);

  localparam int IDX_W = $clog2(BLOCK_COUNT);
  localparam int CNT_W = $clog2(BLOCK_COUNT + 1);
  localparam int ADD_W = ((SIZE_BITS > fba_pkg::SUM_W) ? SIZE_BITS : fba_pkg::SUM_W) + 1;

  // Configuration and control state
  logic [fba_pkg::MODE_W-1:0] fit_mode_q;
  logic [fba_pkg::NUMB_W-1:0] num_blocks_q;
  logic [BLOCK_COUNT-1:0]     busy_q;
  logic [fba_pkg::SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       cmp_v_q;
  logic                       found_q;

  // Payload registers
  logic [fba_pkg::ACT_W-1:0]  act_q;
  logic [SIZE_BITS-1:0]       req_q;
  logic [IDX_W-1:0]           cmp_idx_q;
  logic [IDX_W-1:0]           pick_q;
  logic [SIZE_BITS-1:0]       left_q;
  logic                       granted_q;
  logic [fba_pkg::IDX_FLD_W-1:0]  gblock_q;
  logic [fba_pkg::SIZE_FLD_W-1:0] frag_q;
  logic [fba_pkg::SUM_W-1:0]  total_q;

  logic [CNT_W-1:0]           limit;
  logic                       load_ok;
  logic [SIZE_BITS-1:0]       rd_size;
  logic                       fits;
  logic [SIZE_BITS-1:0]       lo;
  logic                       take;
  logic                       grant;
  logic [ADD_W-1:0]           add;
  logic [fba_pkg::SUM_W-1:0]  sum_next;

  // Entries searched: the block count register capped at the table size.
  assign limit = (32'(num_blocks_q) > BLOCK_COUNT) ? CNT_W'(BLOCK_COUNT)
                                                    : CNT_W'(num_blocks_q);
  assign sts_o.scan_end = (cnt_q == limit);
  assign load_ok = (32'(block_index_i) < BLOCK_COUNT);

  // Size table, read one entry a cycle during a scan.
  fba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (BLOCK_COUNT)
  ) u_size_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr && load_ok),
    .waddr_i (IDX_W'(block_index_i)),
    .wdata_i (SIZE_BITS'(block_size_i)),
    .re_i    (cmd_i.scan_issue),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (rd_size)
  );

  // Fit test of the entry just read and the policy's choice.
  always_comb begin
    fits = !busy_q[cmp_idx_q] && (rd_size >= req_q);
    lo   = rd_size - req_q;
    case (fit_mode_q)
      fba_pkg::FIT_BEST:  take = fits && (!found_q || lo <= left_q);
      fba_pkg::FIT_WORST: take = fits && (!found_q || lo >= left_q);
      default:            take = fits && !found_q;
    endcase
  end

  // Saturating running total.
  assign grant    = (act_q == fba_pkg::ACT_ALLOC) && found_q;
  assign add      = ADD_W'(sum_q) + ADD_W'(left_q);
  assign sum_next = (add > ADD_W'(fba_pkg::SUM_MAX)) ? fba_pkg::SUM_MAX
                                                     : add[fba_pkg::SUM_W-1:0];

  // Control state: configuration, busy marks, total, scan progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q   <= fba_pkg::FIT_FIRST;
      num_blocks_q <= fba_pkg::NUMB_W'(16);
      busy_q       <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      cmp_v_q      <= 1'b0;
      found_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          fba_pkg::CFG_FIT_MODE:   fit_mode_q   <= cfg_data_i[fba_pkg::MODE_W-1:0];
          fba_pkg::CFG_NUM_BLOCKS: num_blocks_q <= cfg_data_i;
          default: ;
        endcase
      end
      cmp_v_q <= cmd_i.scan_issue;
      if (cmd_i.clr_all) begin
        busy_q <= '0;
        sum_q  <= '0;
      end else if (cmd_i.load_wr && load_ok) begin
        busy_q[IDX_W'(block_index_i)] <= 1'b0;
      end else if (cmd_i.finish && grant) begin
        busy_q[pick_q] <= 1'b1;
        sum_q          <= sum_next;
      end
      if (cmd_i.scan_clr) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_issue) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (cmp_v_q && take) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // Request payload, best candidate and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      req_q <= SIZE_BITS'(request_size_i);
    end
    cmp_idx_q <= cnt_q[IDX_W-1:0];
    if (cmp_v_q && take) begin
      pick_q <= cmp_idx_q;
      left_q <= lo;
    end
    if (cmd_i.finish) begin
      granted_q <= grant;
      gblock_q  <= grant ? fba_pkg::IDX_FLD_W'(pick_q) : '0;
      frag_q    <= grant ? fba_pkg::SIZE_FLD_W'(left_q) : '0;
      total_q   <= grant ? sum_next : sum_q;
    end
  end

  assign granted_o        = granted_q;
  assign granted_block_o  = gblock_q;
  assign fragment_o       = frag_q;
  assign total_fragment_o = total_q;

`ifndef SYNTHESIS
  a_grant_marks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && grant) |=> busy_q[$past(pick_q)])
    else $error("granted block not marked busy");
  a_total_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.clr_all |=> (sum_q >= $past(sum_q)))
    else $error("fragment total fell without a release");
  a_found_needs_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(found_q)) |-> $past(cmp_v_q))
    else $error("candidate found without a compared entry");
`endif

endmodule

### rtl/core/fit_block_allocator.sv
// Top level of the fit block allocator: controller, datapath and ports.
//
//   Channel   Direction  Handshake               Contents
//   s_axis    in         s_axis_tvalid/tready    tuser action, tdata index/size/request
//   m_axis    out        m_axis_tvalid/tready    tuser granted, tdata block/fragment/total
//   cfg       in         cfg_valid_i/cfg_ready_o index 0 fit mode, 1 block count
//
// A load, release-all or unused request goes from idle straight to finish; an allocate
// first scans N entries, where N is the block count capped at BLOCK_COUNT, reading the
// size table RAM one entry a cycle through its single read port.
// Reset clears the busy marks and running total and resets the configuration at once;
// there is no clearing pass. A result waits in the output register while the next
// request is taken; a request only stalls at its last cycle if that register is full.
`timescale 1ns / 1ps

module fit_block_allocator #(
  parameter int BLOCK_COUNT = fba_pkg::BLOCK_COUNT_DEF,
  parameter int SIZE_BITS   = fba_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] block_index, [19:4] block_size, [35:20] request_size
  input  logic [fba_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] action
  input  logic [fba_pkg::ACT_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [3:0] granted_block, [19:4] fragment, [39:20] total_fragment
  output logic [fba_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] granted
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fba_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  fba_pkg::fba_cmd_t cmd;
  fba_pkg::fba_sts_t sts;

  logic [fba_pkg::IDX_FLD_W-1:0]  granted_block;
  logic [fba_pkg::SIZE_FLD_W-1:0] fragment;
  logic [fba_pkg::SUM_W-1:0]      total_fragment;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Request sequencing.
  fba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Table, search and results.
  fba_datapath #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .SIZE_BITS   (SIZE_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (s_axis_tuser),
    .block_index_i    (s_axis_tdata[3:0]),
    .block_size_i     (s_axis_tdata[19:4]),
    .request_size_i   (s_axis_tdata[35:20]),
    .granted_o        (m_axis_tuser),
    .granted_block_o  (granted_block),
    .fragment_o       (fragment),
    .total_fragment_o (total_fragment)
  );

  assign m_axis_tdata = {total_fragment, fragment, granted_block};

endmodule
